FILE: design/sbot_pkg.sv
// ----------------------------------------------------------------------------
// sbot_pkg
// shared widths, register indexes and pipeline control word for the swept box
// overlap test unit
// ----------------------------------------------------------------------------
package sbot_pkg;

   // fixed field widths
   localparam int MOVE_W      = 13;
   localparam int OFF_W       = 14;
   localparam int SIZE_W      = 13;
   localparam int BOX_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OWN_OFF_X  = 3'd0,
      CSR_OWN_OFF_Y  = 3'd1,
      CSR_OWN_WIDTH  = 3'd2,
      CSR_OWN_HEIGHT = 3'd3,
      CSR_OWN_FLIP   = 3'd4
   } csr_index_type;

   // control word travelling with each word down the pipeline
   typedef struct packed {
      logic valid;
      logic dx_neg;
      logic dy_neg;
      logic dx_nz;
      logic dy_nz;
   } sbot_flags_type;

endpackage

FILE: design/sbot_geom.sv
// ----------------------------------------------------------------------------
// sbot_geom
// first two pipeline stages: mirroring, box edges and the swept moving box
// ----------------------------------------------------------------------------
module sbot_geom #(
   parameter int COORD_WIDTH = 16,
   parameter int CALC_WIDTH  = 19
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [COORD_WIDTH-1:0]     target_rel_x,
   input  logic signed [COORD_WIDTH-1:0]     target_rel_y,
   input  logic signed [sbot_pkg::MOVE_W-1:0] rel_move_x,
   input  logic signed [sbot_pkg::MOVE_W-1:0] rel_move_y,
   input  logic signed [sbot_pkg::OFF_W-1:0] target_off_x,
   input  logic signed [sbot_pkg::OFF_W-1:0] target_off_y,
   input  logic [sbot_pkg::SIZE_W-1:0]       target_width,
   input  logic [sbot_pkg::SIZE_W-1:0]       target_height,
   input  logic                              target_flip,
   input  logic signed [sbot_pkg::OFF_W-1:0] own_off_x,
   input  logic signed [sbot_pkg::OFF_W-1:0] own_off_y,
   input  logic [sbot_pkg::SIZE_W-1:0]       own_width,
   input  logic [sbot_pkg::SIZE_W-1:0]       own_height,
   input  logic                              own_flip,
   output sbot_pkg::sbot_flags_type          flags,
   output logic signed [CALC_WIDTH-1:0]      t_left,
   output logic signed [CALC_WIDTH-1:0]      t_right,
   output logic signed [CALC_WIDTH-1:0]      t_top,
   output logic signed [CALC_WIDTH-1:0]      t_bottom,
   output logic signed [CALC_WIDTH-1:0]      o_left,
   output logic signed [CALC_WIDTH-1:0]      o_right,
   output logic signed [CALC_WIDTH-1:0]      o_top,
   output logic signed [CALC_WIDTH-1:0]      o_bottom,
   output logic signed [CALC_WIDTH-1:0]      s_left,
   output logic signed [CALC_WIDTH-1:0]      s_right,
   output logic signed [CALC_WIDTH-1:0]      s_top,
   output logic signed [CALC_WIDTH-1:0]      s_bottom,
   output logic [sbot_pkg::MOVE_W-1:0]       abs_x,
   output logic [sbot_pkg::MOVE_W-1:0]       abs_y
);
   import sbot_pkg::*;

   // stage a signals
   logic signed [BOX_W-1:0]      own_x_mir;
   logic signed [BOX_W-1:0]      tgt_x_mir;
   logic signed [MOVE_W:0]       dx_neg_val;
   logic signed [MOVE_W:0]       dy_neg_val;
   sbot_flags_type               a_flags_in, a_flags_ff;
   logic signed [CALC_WIDTH-1:0] a_tl_in, a_tl_ff;
   logic signed [CALC_WIDTH-1:0] a_tt_in, a_tt_ff;
   logic signed [CALC_WIDTH-1:0] a_ol_in, a_ol_ff;
   logic signed [CALC_WIDTH-1:0] a_ot_in, a_ot_ff;
   logic [MOVE_W-1:0]            a_ax_in, a_ax_ff;
   logic [MOVE_W-1:0]            a_ay_in, a_ay_ff;
   logic [SIZE_W-1:0]            a_tw_ff, a_th_ff, a_ow_ff, a_oh_ff;

   // stage b signals
   logic signed [CALC_WIDTH-1:0] tw_x, th_x, ow_x, oh_x, ax_x, ay_x;
   sbot_flags_type               b_flags_ff;
   logic signed [CALC_WIDTH-1:0] b_tl_ff, b_tr_in, b_tr_ff, b_tt_ff, b_tb_in, b_tb_ff;
   logic signed [CALC_WIDTH-1:0] b_ol_ff, b_or_in, b_or_ff, b_ot_ff, b_ob_in, b_ob_ff;
   logic signed [CALC_WIDTH-1:0] b_sl_in, b_sl_ff, b_sr_in, b_sr_ff;
   logic signed [CALC_WIDTH-1:0] b_st_in, b_st_ff, b_sb_in, b_sb_ff;
   logic [MOVE_W-1:0]            b_ax_ff, b_ay_ff;

   // mirrored left edges: -(offset + width) when flipped
   always_comb begin
      own_x_mir = BOX_W'(own_off_x);
      if (own_flip) begin
         own_x_mir = -(BOX_W'(own_off_x) + $signed(BOX_W'(own_width)));
      end
      tgt_x_mir = BOX_W'(target_off_x);
      if (target_flip) begin
         tgt_x_mir = -(BOX_W'(target_off_x) + $signed(BOX_W'(target_width)));
      end
   end

   // exact magnitudes of the motion
   assign dx_neg_val = -((MOVE_W+1)'(rel_move_x));
   assign dy_neg_val = -((MOVE_W+1)'(rel_move_y));
   assign a_ax_in = rel_move_x[MOVE_W-1] ? dx_neg_val[MOVE_W-1:0] : rel_move_x;
   assign a_ay_in = rel_move_y[MOVE_W-1] ? dy_neg_val[MOVE_W-1:0] : rel_move_y;

   // target origin corner and own box origin corner
   assign a_tl_in = CALC_WIDTH'(target_rel_x) + CALC_WIDTH'(tgt_x_mir);
   assign a_tt_in = CALC_WIDTH'(target_rel_y) + CALC_WIDTH'(target_off_y);
   assign a_ol_in = CALC_WIDTH'(own_x_mir);
   assign a_ot_in = CALC_WIDTH'(own_off_y);

   always_comb begin
      a_flags_in.valid  = in_valid;
      a_flags_in.dx_neg = rel_move_x[MOVE_W-1];
      a_flags_in.dy_neg = rel_move_y[MOVE_W-1];
      a_flags_in.dx_nz  = (rel_move_x != '0);
      a_flags_in.dy_nz  = (rel_move_y != '0);
   end

   // stage a registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_flags_ff <= '0;
      end else begin
         a_flags_ff <= a_flags_in;
      end
      a_tl_ff <= a_tl_in;
      a_tt_ff <= a_tt_in;
      a_ol_ff <= a_ol_in;
      a_ot_ff <= a_ot_in;
      a_ax_ff <= a_ax_in;
      a_ay_ff <= a_ay_in;
      a_tw_ff <= target_width;
      a_th_ff <= target_height;
      a_ow_ff <= own_width;
      a_oh_ff <= own_height;
   end

   // far edges and the box stretched back along the motion
   assign tw_x = CALC_WIDTH'(a_tw_ff);
   assign th_x = CALC_WIDTH'(a_th_ff);
   assign ow_x = CALC_WIDTH'(a_ow_ff);
   assign oh_x = CALC_WIDTH'(a_oh_ff);
   assign ax_x = CALC_WIDTH'(a_ax_ff);
   assign ay_x = CALC_WIDTH'(a_ay_ff);

   assign b_tr_in = a_tl_ff + tw_x;
   assign b_tb_in = a_tt_ff + th_x;
   assign b_or_in = a_ol_ff + ow_x;
   assign b_ob_in = a_ot_ff + oh_x;
   assign b_sl_in = a_flags_ff.dx_neg ? a_ol_ff : a_ol_ff - ax_x;
   assign b_sr_in = a_flags_ff.dx_neg ? a_ol_ff + ow_x + ax_x : a_ol_ff + ow_x;
   assign b_st_in = a_flags_ff.dy_neg ? a_ot_ff : a_ot_ff - ay_x;
   assign b_sb_in = a_flags_ff.dy_neg ? a_ot_ff + oh_x + ay_x : a_ot_ff + oh_x;

   // stage b registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_flags_ff <= '0;
      end else begin
         b_flags_ff <= a_flags_ff;
      end
      b_tl_ff <= a_tl_ff;
      b_tr_ff <= b_tr_in;
      b_tt_ff <= a_tt_ff;
      b_tb_ff <= b_tb_in;
      b_ol_ff <= a_ol_ff;
      b_or_ff <= b_or_in;
      b_ot_ff <= a_ot_ff;
      b_ob_ff <= b_ob_in;
      b_sl_ff <= b_sl_in;
      b_sr_ff <= b_sr_in;
      b_st_ff <= b_st_in;
      b_sb_ff <= b_sb_in;
      b_ax_ff <= a_ax_ff;
      b_ay_ff <= a_ay_ff;
   end

   assign flags    = b_flags_ff;
   assign t_left   = b_tl_ff;
   assign t_right  = b_tr_ff;
   assign t_top    = b_tt_ff;
   assign t_bottom = b_tb_ff;
   assign o_left   = b_ol_ff;
   assign o_right  = b_or_ff;
   assign o_top    = b_ot_ff;
   assign o_bottom = b_ob_ff;
   assign s_left   = b_sl_ff;
   assign s_right  = b_sr_ff;
   assign s_top    = b_st_ff;
   assign s_bottom = b_sb_ff;
   assign abs_x    = b_ax_ff;
   assign abs_y    = b_ay_ff;

endmodule

FILE: design/sbot_interval.sv
// ----------------------------------------------------------------------------
// sbot_interval
// third pipeline stage: strict overlap of the swept box and the per-axis
// entry and exit numerators
// ----------------------------------------------------------------------------
module sbot_interval #(
   parameter int CALC_WIDTH = 19
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sbot_pkg::sbot_flags_type     in_flags,
   input  logic signed [CALC_WIDTH-1:0] t_left,
   input  logic signed [CALC_WIDTH-1:0] t_right,
   input  logic signed [CALC_WIDTH-1:0] t_top,
   input  logic signed [CALC_WIDTH-1:0] t_bottom,
   input  logic signed [CALC_WIDTH-1:0] o_left,
   input  logic signed [CALC_WIDTH-1:0] o_right,
   input  logic signed [CALC_WIDTH-1:0] o_top,
   input  logic signed [CALC_WIDTH-1:0] o_bottom,
   input  logic signed [CALC_WIDTH-1:0] s_left,
   input  logic signed [CALC_WIDTH-1:0] s_right,
   input  logic signed [CALC_WIDTH-1:0] s_top,
   input  logic signed [CALC_WIDTH-1:0] s_bottom,
   input  logic [sbot_pkg::MOVE_W-1:0]  abs_x,
   input  logic [sbot_pkg::MOVE_W-1:0]  abs_y,
   output sbot_pkg::sbot_flags_type     out_flags,
   output logic                         overlap,
   output logic signed [CALC_WIDTH-1:0] x_lo,
   output logic signed [CALC_WIDTH-1:0] x_hi,
   output logic signed [CALC_WIDTH-1:0] y_lo,
   output logic signed [CALC_WIDTH-1:0] y_hi,
   output logic [sbot_pkg::MOVE_W-1:0]  x_den,
   output logic [sbot_pkg::MOVE_W-1:0]  y_den
);
   import sbot_pkg::*;

   sbot_flags_type               flags_ff;
   logic                         ov_in, ov_ff;
   logic signed [CALC_WIDTH-1:0] xlo_in, xlo_ff, xhi_in, xhi_ff;
   logic signed [CALC_WIDTH-1:0] ylo_in, ylo_ff, yhi_in, yhi_ff;
   logic [MOVE_W-1:0]            xd_ff, yd_ff;

   // strict overlap on both axes
   assign ov_in = (s_left < t_right) && (s_right > t_left) &&
                  (s_top < t_bottom) && (s_bottom > t_top);

   // entry and exit numerators, sign folded so the denominator is the magnitude
   assign xlo_in = in_flags.dx_neg ? o_left - t_right  : t_left - o_right;
   assign xhi_in = in_flags.dx_neg ? o_right - t_left  : t_right - o_left;
   assign ylo_in = in_flags.dy_neg ? o_top - t_bottom  : t_top - o_bottom;
   assign yhi_in = in_flags.dy_neg ? o_bottom - t_top  : t_bottom - o_top;

   // stage c registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= in_flags;
      end
      ov_ff  <= ov_in;
      xlo_ff <= xlo_in;
      xhi_ff <= xhi_in;
      ylo_ff <= ylo_in;
      yhi_ff <= yhi_in;
      xd_ff  <= abs_x;
      yd_ff  <= abs_y;
   end

   assign out_flags = flags_ff;
   assign overlap   = ov_ff;
   assign x_lo      = xlo_ff;
   assign x_hi      = xhi_ff;
   assign y_lo      = ylo_ff;
   assign y_hi      = yhi_ff;
   assign x_den     = xd_ff;
   assign y_den     = yd_ff;

endmodule

FILE: design/sbot_time_cmp.sv
// ----------------------------------------------------------------------------
// sbot_time_cmp
// last two pipeline stages: cross-multiplied entry/exit time compares and
// the result register
// ----------------------------------------------------------------------------
module sbot_time_cmp #(
   parameter int CALC_WIDTH = 19
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sbot_pkg::sbot_flags_type     in_flags,
   input  logic                         overlap,
   input  logic signed [CALC_WIDTH-1:0] x_lo,
   input  logic signed [CALC_WIDTH-1:0] x_hi,
   input  logic signed [CALC_WIDTH-1:0] y_lo,
   input  logic signed [CALC_WIDTH-1:0] y_hi,
   input  logic [sbot_pkg::MOVE_W-1:0]  x_den,
   input  logic [sbot_pkg::MOVE_W-1:0]  y_den,
   output logic                         rsp_strobe,
   output logic                         rsp_hit
);
   import sbot_pkg::*;

   localparam int PROD_W = CALC_WIDTH + MOVE_W + 1;

   logic signed [PROD_W-1:0] xd_x, yd_x;
   logic signed [PROD_W-1:0] yhi_xd_in, yhi_xd_ff, xlo_yd_in, xlo_yd_ff;
   logic signed [PROD_W-1:0] xhi_yd_in, xhi_yd_ff, ylo_xd_in, ylo_xd_ff;
   logic                     d_valid_ff, d_ov_ff, d_both_ff;
   logic                     miss;
   logic                     strobe_ff, hit_ff;

   // four products, one per side of the two interval compares
   assign xd_x = PROD_W'($signed({1'b0, x_den}));
   assign yd_x = PROD_W'($signed({1'b0, y_den}));
   assign yhi_xd_in = PROD_W'(y_hi) * xd_x;
   assign xlo_yd_in = PROD_W'(x_lo) * yd_x;
   assign xhi_yd_in = PROD_W'(x_hi) * yd_x;
   assign ylo_xd_in = PROD_W'(y_lo) * xd_x;

   // stage d registers
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= in_flags.valid;
      end
      d_ov_ff   <= overlap;
      d_both_ff <= in_flags.dx_nz & in_flags.dy_nz;
      yhi_xd_ff <= yhi_xd_in;
      xlo_yd_ff <= xlo_yd_in;
      xhi_yd_ff <= xhi_yd_in;
      ylo_xd_ff <= ylo_xd_in;
   end

   // with motion on both axes, the intervals fail to meet when one exit comes before the other entry
   assign miss = d_both_ff && ((yhi_xd_ff < xlo_yd_ff) || (xhi_yd_ff < ylo_xd_ff));

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= d_valid_ff;
      end
      hit_ff <= d_ov_ff & ~miss;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_hit    = hit_ff;

endmodule

FILE: design/swept_box_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// swept_box_overlap_test_unit
// tests whether a moving box, set up in registers, met a target box during
// one frame of relative motion
// ----------------------------------------------------------------------------
// Fully pipelined: one test word is taken in every clock cycle and busy never
// rises. Each result comes out on rsp_hit with rsp_strobe high for one cycle,
// having passed five register stages, the first loaded at the edge that took
// its request (two geometry stages, one overlap and interval stage, one
// multiply stage, one result register), in request order. The receiver has
// no way to hold results off, so it must take every strobed word. csr_ready
// is always high; registers should be written only while no test is in flight.
module swept_box_overlap_test_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_WIDTH-1:0]          req_target_rel_x,
   input  logic signed [COORD_WIDTH-1:0]          req_target_rel_y,
   input  logic signed [sbot_pkg::MOVE_W-1:0]     req_rel_move_x,
   input  logic signed [sbot_pkg::MOVE_W-1:0]     req_rel_move_y,
   input  logic signed [sbot_pkg::OFF_W-1:0]      req_target_off_x,
   input  logic signed [sbot_pkg::OFF_W-1:0]      req_target_off_y,
   input  logic [sbot_pkg::SIZE_W-1:0]            req_target_width,
   input  logic [sbot_pkg::SIZE_W-1:0]            req_target_height,
   input  logic                                   req_target_flip,
   // result channel
   output logic                                   rsp_strobe,
   output logic                                   rsp_hit,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sbot_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sbot_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import sbot_pkg::*;

   localparam int CALC_WIDTH = ((COORD_WIDTH > BOX_W) ? COORD_WIDTH : BOX_W) + 3;

   logic signed [OFF_W-1:0]      own_off_x_ff, own_off_y_ff;
   logic [SIZE_W-1:0]            own_width_ff, own_height_ff;
   logic                         own_flip_ff;
   logic                         req_take;
   csr_index_type                csr_sel;

   sbot_flags_type               g_flags, i_flags;
   logic signed [CALC_WIDTH-1:0] t_left, t_right, t_top, t_bottom;
   logic signed [CALC_WIDTH-1:0] o_left, o_right, o_top, o_bottom;
   logic signed [CALC_WIDTH-1:0] s_left, s_right, s_top, s_bottom;
   logic [MOVE_W-1:0]            abs_x, abs_y, x_den, y_den;
   logic                         overlap;
   logic signed [CALC_WIDTH-1:0] x_lo, x_hi, y_lo, y_hi;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign req_take  = start & ~busy;
   assign csr_sel   = csr_index_type'(csr_index);

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         own_off_x_ff  <= '0;
         own_off_y_ff  <= '0;
         own_width_ff  <= '0;
         own_height_ff <= '0;
         own_flip_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_sel)
            CSR_OWN_OFF_X:  own_off_x_ff  <= csr_wdata[OFF_W-1:0];
            CSR_OWN_OFF_Y:  own_off_y_ff  <= csr_wdata[OFF_W-1:0];
            CSR_OWN_WIDTH:  own_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_OWN_HEIGHT: own_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_OWN_FLIP:   own_flip_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // box geometry stages
   sbot_geom #(
      .COORD_WIDTH (COORD_WIDTH),
      .CALC_WIDTH  (CALC_WIDTH)
   ) u_geom (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_take),
      .target_rel_x  (req_target_rel_x),
      .target_rel_y  (req_target_rel_y),
      .rel_move_x    (req_rel_move_x),
      .rel_move_y    (req_rel_move_y),
      .target_off_x  (req_target_off_x),
      .target_off_y  (req_target_off_y),
      .target_width  (req_target_width),
      .target_height (req_target_height),
      .target_flip   (req_target_flip),
      .own_off_x     (own_off_x_ff),
      .own_off_y     (own_off_y_ff),
      .own_width     (own_width_ff),
      .own_height    (own_height_ff),
      .own_flip      (own_flip_ff),
      .flags         (g_flags),
      .t_left        (t_left),
      .t_right       (t_right),
      .t_top         (t_top),
      .t_bottom      (t_bottom),
      .o_left        (o_left),
      .o_right       (o_right),
      .o_top         (o_top),
      .o_bottom      (o_bottom),
      .s_left        (s_left),
      .s_right       (s_right),
      .s_top         (s_top),
      .s_bottom      (s_bottom),
      .abs_x         (abs_x),
      .abs_y         (abs_y)
   );

   // overlap and interval numerators
   sbot_interval #(
      .CALC_WIDTH (CALC_WIDTH)
   ) u_interval (
      .clock     (clock),
      .reset     (reset),
      .in_flags  (g_flags),
      .t_left    (t_left),
      .t_right   (t_right),
      .t_top     (t_top),
      .t_bottom  (t_bottom),
      .o_left    (o_left),
      .o_right   (o_right),
      .o_top     (o_top),
      .o_bottom  (o_bottom),
      .s_left    (s_left),
      .s_right   (s_right),
      .s_top     (s_top),
      .s_bottom  (s_bottom),
      .abs_x     (abs_x),
      .abs_y     (abs_y),
      .out_flags (i_flags),
      .overlap   (overlap),
      .x_lo      (x_lo),
      .x_hi      (x_hi),
      .y_lo      (y_lo),
      .y_hi      (y_hi),
      .x_den     (x_den),
      .y_den     (y_den)
   );

   // time compares and result
   sbot_time_cmp #(
      .CALC_WIDTH (CALC_WIDTH)
   ) u_time_cmp (
      .clock      (clock),
      .reset      (reset),
      .in_flags   (i_flags),
      .overlap    (overlap),
      .x_lo       (x_lo),
      .x_hi       (x_hi),
      .y_lo       (y_lo),
      .y_hi       (y_hi),
      .x_den      (x_den),
      .y_den      (y_den),
      .rsp_strobe (rsp_strobe),
      .rsp_hit    (rsp_hit)
   );

endmodule

FILE: verif/tb_swept_box_overlap_test_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swept_box_overlap_test_unit
// self-checking bench for the swept box overlap test unit: a scoreboard
// predicts the hit flag of every accepted test word from its own copy of the
// moving box registers and checks each strobed result in order; directed
// words cover edges, sweeps and touching time windows, then random phases run
// under several register settings and sender idle rates
// ----------------------------------------------------------------------------
module tb_swept_box_overlap_test_unit;
   import sbot_pkg::*;

   localparam int COORD_W        = 16;
   localparam int PIPE_DEPTH     = 5;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 200;

   // one test word as seen on the request ports
   typedef struct {
      logic signed [COORD_W-1:0] rel_x;
      logic signed [COORD_W-1:0] rel_y;
      logic signed [MOVE_W-1:0]  move_x;
      logic signed [MOVE_W-1:0]  move_y;
      logic signed [OFF_W-1:0]   off_x;
      logic signed [OFF_W-1:0]   off_y;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
      logic                      flip;
   } overlap_req_type;

   // hit predictor and store of pending hit flags
   class hit_scoreboard_type;
      logic signed [OFF_W-1:0] own_off_x;
      logic signed [OFF_W-1:0] own_off_y;
      logic [SIZE_W-1:0]       own_width;
      logic [SIZE_W-1:0]       own_height;
      logic                    own_flip;
      bit                      pending_hits[$];
      int                      errors;

      function new();
         own_off_x  = '0;
         own_off_y  = '0;
         own_width  = '0;
         own_height = '0;
         own_flip   = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_OWN_OFF_X:  own_off_x  = data;
            CSR_OWN_OFF_Y:  own_off_y  = data;
            CSR_OWN_WIDTH:  own_width  = data[SIZE_W-1:0];
            CSR_OWN_HEIGHT: own_height = data[SIZE_W-1:0];
            CSR_OWN_FLIP:   own_flip   = data[0];
            default: ;
         endcase
      endfunction

      // entry and exit numerators on one axis, denominator made positive
      function void axis_window(input longint d, t_lo, t_hi, o_lo, o_hi,
                                output longint lo, hi, den);
         if (d > 0) begin
            lo  = t_lo - o_hi;
            hi  = t_hi - o_lo;
            den = d;
         end else begin
            lo  = o_lo - t_hi;
            hi  = o_hi - t_lo;
            den = -d;
         end
      endfunction

      function bit predict_hit(overlap_req_type r);
         longint dx, dy, ax, ay, tox, tw, th, oox, ooy, ow, oh;
         longint o_l, o_r, o_t, o_b, t_l, t_r, t_t, t_b, s_l, s_r, s_t, s_b;
         longint xlo, xhi, xden, ylo, yhi, yden;
         bit     hit;
         dx  = longint'(r.move_x);
         dy  = longint'(r.move_y);
         tox = longint'(r.off_x);
         tw  = longint'(r.width);
         th  = longint'(r.height);
         oox = longint'(own_off_x);
         ooy = longint'(own_off_y);
         ow  = longint'(own_width);
         oh  = longint'(own_height);
         ax  = (dx < 0) ? -dx : dx;
         ay  = (dy < 0) ? -dy : dy;
         // mirrored boxes start at minus their far edge
         if (own_flip) oox = -(oox + ow);
         if (r.flip) tox = -(tox + tw);
         o_l = oox;
         o_r = oox + ow;
         o_t = ooy;
         o_b = ooy + oh;
         t_l = longint'(r.rel_x) + tox;
         t_r = t_l + tw;
         t_t = longint'(r.rel_y) + longint'(r.off_y);
         t_b = t_t + th;
         // moving box stretched back along the motion
         s_l = (dx < 0) ? o_l : o_l - ax;
         s_r = s_l + ow + ax;
         s_t = (dy < 0) ? o_t : o_t - ay;
         s_b = s_t + oh + ay;
         hit = (s_l < t_r) && (s_r > t_l) && (s_t < t_b) && (s_b > t_t);
         // diagonal motion: the axis time windows must meet
         if (hit && dx != 0 && dy != 0) begin
            axis_window(dx, t_l, t_r, o_l, o_r, xlo, xhi, xden);
            axis_window(dy, t_t, t_b, o_t, o_b, ylo, yhi, yden);
            if (yhi * xden < xlo * yden || xhi * yden < ylo * xden) hit = 1'b0;
         end
         return hit;
      endfunction

      function void note_request(overlap_req_type r);
         pending_hits.insert(pending_hits.size(), predict_hit(r));
      endfunction

      function void check_hit(logic actual);
         bit expected;
         if (pending_hits.size() == 0) begin
            $display("%0t: result word with none expected, expected none, actual %b",
                     $time, actual);
            errors++;
         end else begin
            expected = pending_hits.pop_front();
            if (actual !== expected) begin
               $display("%0t: hit mismatch, expected %b, actual %b",
                        $time, expected, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return pending_hits.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       start = 1'b0;
   logic                       busy;
   logic signed [COORD_W-1:0]  req_target_rel_x = '0;
   logic signed [COORD_W-1:0]  req_target_rel_y = '0;
   logic signed [MOVE_W-1:0]   req_rel_move_x = '0;
   logic signed [MOVE_W-1:0]   req_rel_move_y = '0;
   logic signed [OFF_W-1:0]    req_target_off_x = '0;
   logic signed [OFF_W-1:0]    req_target_off_y = '0;
   logic [SIZE_W-1:0]          req_target_width = '0;
   logic [SIZE_W-1:0]          req_target_height = '0;
   logic                       req_target_flip = 1'b0;
   logic                       rsp_strobe;
   logic                       rsp_hit;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   hit_scoreboard_type sb = new();
   int                 quiet_cycles = 0;

   swept_box_overlap_test_unit #(.COORD_WIDTH(COORD_W)) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_target_rel_x  (req_target_rel_x),
      .req_target_rel_y  (req_target_rel_y),
      .req_rel_move_x    (req_rel_move_x),
      .req_rel_move_y    (req_rel_move_y),
      .req_target_off_x  (req_target_off_x),
      .req_target_off_y  (req_target_off_y),
      .req_target_width  (req_target_width),
      .req_target_height (req_target_height),
      .req_target_flip   (req_target_flip),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watch accepted words, results and register writes at each edge
   always @(posedge clock) begin
      overlap_req_type seen;
      seen.rel_x  = req_target_rel_x;
      seen.rel_y  = req_target_rel_y;
      seen.move_x = req_rel_move_x;
      seen.move_y = req_rel_move_y;
      seen.off_x  = req_target_off_x;
      seen.off_y  = req_target_off_y;
      seen.width  = req_target_width;
      seen.height = req_target_height;
      seen.flip   = req_target_flip;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index_type'(csr_index), csr_wdata);
         if (start && !busy) sb.note_request(seen);
         if (rsp_strobe) sb.check_hit(rsp_hit);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[swept_box_overlap_test_unit] ERROR");
         $finish;
      end
   end

   function automatic int small_signed(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic overlap_req_type make_req(int rx, int ry, int mx, int my,
                                                int ox, int oy, int w, int h, bit f);
      overlap_req_type r;
      r.rel_x  = COORD_W'(rx);
      r.rel_y  = COORD_W'(ry);
      r.move_x = MOVE_W'(mx);
      r.move_y = MOVE_W'(my);
      r.off_x  = OFF_W'(ox);
      r.off_y  = OFF_W'(oy);
      r.width  = SIZE_W'(w);
      r.height = SIZE_W'(h);
      r.flip   = f;
      return r;
   endfunction

   // random word: mostly a small target placed around the moving box, some raw
   function automatic overlap_req_type random_req();
      overlap_req_type r;
      longint          base_x;
      int              own_w, own_h, mx, my;
      if ($urandom_range(0, 3) == 0) begin
         return make_req($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
      end
      own_w  = int'(sb.own_width);
      own_h  = int'(sb.own_height);
      base_x = sb.own_flip ? -(longint'(sb.own_off_x) + own_w) : longint'(sb.own_off_x);
      mx = ($urandom_range(0, 7) == 0) ? 0 : small_signed(96);
      my = ($urandom_range(0, 7) == 0) ? 0 : small_signed(96);
      r = make_req(int'(base_x) + int'($urandom_range(0, own_w + 320)) - 160,
                   int'(sb.own_off_y) + int'($urandom_range(0, own_h + 320)) - 160,
                   mx, my, small_signed(64), small_signed(64),
                   $urandom_range(0, 64), $urandom_range(0, 64),
                   1'($urandom_range(0, 1)));
      return r;
   endfunction

   // offer one word, after a random run of idle cycles
   task automatic send_request(overlap_req_type r, int idle_pct);
      bit taken;
      while (int'($urandom_range(0, 99)) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_target_rel_x  <= r.rel_x;
      req_target_rel_y  <= r.rel_y;
      req_rel_move_x    <= r.move_x;
      req_rel_move_y    <= r.move_y;
      req_target_off_x  <= r.off_x;
      req_target_off_y  <= r.off_y;
      req_target_width  <= r.width;
      req_target_height <= r.height;
      req_target_flip   <= r.flip;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // one register word; valid is left high for the caller to drop
   task automatic write_csr(csr_index_type idx, int value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic set_own_box(int ox, int oy, int w, int h, bit f);
      write_csr(CSR_OWN_OFF_X, ox);
      write_csr(CSR_OWN_OFF_Y, oy);
      write_csr(CSR_OWN_WIDTH, w);
      write_csr(CSR_OWN_HEIGHT, h);
      write_csr(CSR_OWN_FLIP, f);
      csr_valid <= 1'b0;
   endtask

   // let every expected word come back, then clear the pipeline
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   initial begin
      int idle_pct;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty moving box straight out of reset
      send_request(make_req(0, 0, 0, 0, -8, -8, 16, 16, 0), 0);
      send_request(make_req(0, 0, 16, 0, -8, -8, 16, 16, 0), 0);
      send_request(make_req(0, 0, 16, -16, -8, -8, 16, 16, 0), 0);
      drain();

      // 16 x 16 box at the origin
      set_own_box(0, 0, 16, 16, 0);
      send_request(make_req(0, 0, 0, 0, 0, 0, 16, 16, 0), 0);
      send_request(make_req(16, 0, 0, 0, 0, 0, 16, 16, 0), 0);
      send_request(make_req(8, 8, 0, 0, 0, 0, 0, 16, 0), 0);
      send_request(make_req(-40, 0, 16, 0, 0, 0, 16, 16, 0), 0);
      send_request(make_req(0, -40, 0, -16, 0, 0, 16, 16, 0), 0);
      send_request(make_req(-8, -8, 16, 16, 0, 0, 16, 16, 0), 0);
      send_request(make_req(20, 20, -16, -16, 0, 0, 16, 16, 0), 0);
      send_request(make_req(-30, 10, 16, -16, 0, 0, 16, 16, 0), 0);
      // time windows that just touch, then just miss
      send_request(make_req(0, 0, 32, 16, -40, 12, 32, 16, 0), 0);
      send_request(make_req(0, 0, 32, 16, -40, 13, 32, 16, 0), 0);
      // mirrored target
      send_request(make_req(0, 0, 0, 0, -24, 0, 16, 16, 1), 0);
      // field extremes
      send_request(make_req(32767, 32767, 4095, 4095, 8191, 8191, 8191, 8191, 1), 0);
      send_request(make_req(-32768, -32768, -4096, -4096, -8192, -8192, 8191, 8191, 0), 0);
      send_request(make_req(-32768, 32767, -4096, 4095, 8191, -8192, 0, 0, 1), 0);
      drain();

      // mirrored moving box spanning -8 to 8
      set_own_box(-8, 0, 16, 16, 1);
      send_request(make_req(0, 0, 0, 0, 0, 0, 16, 16, 0), 0);
      send_request(make_req(-16, 0, 0, 0, 0, 0, 8, 8, 0), 0);
      send_request(make_req(-16, 0, 4, 4, 0, 0, 8, 8, 1), 0);
      drain();

      // random phases across register settings and sender idle rates
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: set_own_box(-8192, 8191, 8191, 0, 1);
            2: set_own_box(8191, -8192, 0, 8191, 0);
            5: set_own_box($urandom, $urandom, $urandom, $urandom,
                           1'($urandom_range(0, 1)));
            default: set_own_box(small_signed(64), small_signed(64),
                                 $urandom_range(0, 64), $urandom_range(0, 64),
                                 1'($urandom_range(0, 1)));
         endcase
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 55;
            default: idle_pct = 21;
         endcase
         repeat (PHASE_WORDS) send_request(random_req(), idle_pct);
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[swept_box_overlap_test_unit] OK");
      end else begin
         $display("[swept_box_overlap_test_unit] ERROR");
      end
      $finish;
   end

endmodule
